// ===== hdl/hsd_pkg.sv =====
// Shared types, constants and lookup functions for the Hall sector decoder.
// No dependencies; the tracker, the top level and the testbench import this package.
package hsd_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int MOTOR_W = 2;

   typedef enum logic [1:0] {
      ST_VALID    = 2'd0,
      ST_BAD_CODE = 2'd1,
      ST_BAD_STEP = 2'd2,
      ST_CLEARED  = 2'd3
   } status_type;

   localparam logic REQ_CAPTURE = 1'b0;
   localparam logic REQ_CLEAR   = 1'b1;

   // wiring orders, listed as the lines that land in code bit2..bit0
   localparam logic [2:0] WO_H3H2H1 = 3'd0;
   localparam logic [2:0] WO_H3H1H2 = 3'd1;
   localparam logic [2:0] WO_H2H3H1 = 3'd2;
   localparam logic [2:0] WO_H2H1H3 = 3'd3;
   localparam logic [2:0] WO_H1H2H3 = 3'd4;
   localparam logic [2:0] WO_H1H3H2 = 3'd5;

   localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
   localparam logic [2:0] HALL_ALL_HIGH = 3'b111;

   localparam logic signed [1:0] DIR_NONE = 2'sb00;
   localparam logic signed [1:0] DIR_CW   = 2'sb01;
   localparam logic signed [1:0] DIR_CCW  = 2'sb11;

   localparam logic signed [31:0] STEPS_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] STEPS_MIN = 32'sh8000_0000;

   // register indexes on the configuration port
   localparam logic REG_WIRE_ORDER = 1'b0;
   localparam logic REG_STEP_ANGLE = 1'b1;

   localparam logic [21:0] STEP_ANGLE_RESET = 22'd3932160;

   typedef struct packed {
      logic               req_type;
      logic [MOTOR_W-1:0] motor;
      logic [2:0]         hall_bits;
   } trk_item_type;

   typedef struct packed {
      status_type         status;
      logic [2:0]         hall_code;
      logic [2:0]         sector;
      logic signed [1:0]  direction;
      logic signed [31:0] steps;
   } trk_result_type;

   function automatic logic [2:0] hsd_reorder(input logic [2:0] order, input logic [2:0] x);
      logic h1, h2, h3;
      logic [2:0] r;
      h1 = x[0];
      h2 = x[1];
      h3 = x[2];
      case (order)
         WO_H3H1H2: r = {h3, h1, h2};
         WO_H2H3H1: r = {h2, h3, h1};
         WO_H2H1H3: r = {h2, h1, h3};
         WO_H1H2H3: r = {h1, h2, h3};
         WO_H1H3H2: r = {h1, h3, h2};
         default:   r = x;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] hsd_next_cw(input logic [2:0] c);
      logic [2:0] r;
      case (c)
         3'd1:    r = 3'd5;
         3'd2:    r = 3'd3;
         3'd3:    r = 3'd1;
         3'd4:    r = 3'd6;
         3'd5:    r = 3'd4;
         3'd6:    r = 3'd2;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] hsd_next_ccw(input logic [2:0] c);
      logic [2:0] r;
      case (c)
         3'd1:    r = 3'd3;
         3'd2:    r = 3'd6;
         3'd3:    r = 3'd2;
         3'd4:    r = 3'd5;
         3'd5:    r = 3'd1;
         3'd6:    r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] hsd_code_sector(input logic [2:0] c);
      logic [2:0] r;
      case (c)
         3'd1:    r = 3'd4;
         3'd2:    r = 3'd2;
         3'd3:    r = 3'd3;
         3'd5:    r = 3'd5;
         3'd6:    r = 3'd1;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] hsd_sector_deg(input logic [2:0] s);
      logic [8:0] r;
      case (s)
         3'd0:    r = 9'd0;
         3'd1:    r = 9'd60;
         3'd2:    r = 9'd120;
         3'd3:    r = 9'd180;
         3'd4:    r = 9'd240;
         3'd5:    r = 9'd300;
         3'd6:    r = 9'd360 - 9'd0;
         default: r = 9'd420 - 9'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/hsd_req_if.sv =====
// Request channel: valid/ready handshake carrying one Hall capture or clear.
// Payload widths follow the field list of the decoder; no package needed.
interface hsd_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [1:0] motor;
   logic [2:0] hall_bits;

   modport source (output valid, req_type, motor, hall_bits, input ready);
   modport sink (input valid, req_type, motor, hall_bits, output ready);
endinterface

// ===== hdl/hsd_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one decoded result item.
// Payload widths follow the result field list; no package needed.
interface hsd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [2:0]         hall_code;
   logic [2:0]         sector_index;
   logic [8:0]         electrical_deg;
   logic signed [1:0]  direction;
   logic signed [31:0] step_count;
   logic signed [53:0] mech_angle_q16;

   modport source (output valid, status, hall_code, sector_index, electrical_deg,
                   direction, step_count, mech_angle_q16, input ready);
   modport sink (input valid, status, hall_code, sector_index, electrical_deg,
                 direction, step_count, mech_angle_q16, output ready);
endinterface

// ===== hdl/hsd_tracker.sv =====
// Per-motor Hall state (seed flag, current code, sector, step count) and its update.
// Uses hsd_pkg for the item/result structs and the code lookup functions.
module hsd_tracker import hsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic [2:0]     wire_order,
   input  trk_item_type   item,
   input  logic           upd_en,
   output trk_result_type result
);

   logic               first_pending_ff [NUM_MOTORS];
   logic [2:0]         curr_code_ff     [NUM_MOTORS];
   logic [2:0]         sector_ff        [NUM_MOTORS];
   logic signed [31:0] steps_ff         [NUM_MOTORS];

   // the previous code is never needed after the step check, so it is not stored
   logic               first_pending_in;
   logic [2:0]         curr_code_in;
   logic [2:0]         sector_in;
   logic signed [31:0] steps_in;
   logic               wr;

   logic               motor_ok;
   logic [2:0]         code;
   logic [2:0]         prev;
   logic               bad_step;
   logic signed [1:0]  dir;

   assign motor_ok = {1'b0, item.motor} < 3'(NUM_MOTORS);

   always_comb begin
      first_pending_in = first_pending_ff[item.motor];
      curr_code_in     = curr_code_ff[item.motor];
      sector_in        = sector_ff[item.motor];
      steps_in         = steps_ff[item.motor];
      wr               = 1'b0;
      code             = hsd_reorder(wire_order, item.hall_bits);
      prev             = HALL_ALL_LOW;
      bad_step         = 1'b0;
      dir              = DIR_NONE;

      result.status    = ST_BAD_CODE;
      result.hall_code = '0;
      result.sector    = '0;
      result.direction = DIR_NONE;
      result.steps     = '0;

      if (motor_ok) begin
         if (item.req_type == REQ_CLEAR) begin
            wr               = 1'b1;
            first_pending_in = 1'b1;
            curr_code_in     = '0;
            sector_in        = '0;
            steps_in         = '0;
            result.status    = ST_CLEARED;
         end else begin
            result.hall_code = curr_code_ff[item.motor];
            result.sector    = sector_ff[item.motor];
            result.steps     = steps_ff[item.motor];
            if (code == HALL_ALL_LOW || code == HALL_ALL_HIGH) begin
               result.status = ST_BAD_CODE;
            end else begin
               wr               = 1'b1;
               // first capture after a clear seeds the previous code too
               prev             = first_pending_ff[item.motor] ? code
                                                               : curr_code_ff[item.motor];
               first_pending_in = 1'b0;
               curr_code_in     = code;
               result.hall_code = code;
               if (code != prev) begin
                  if (prev == HALL_ALL_LOW || prev == HALL_ALL_HIGH) begin
                     bad_step = 1'b1;
                  end else if (code == hsd_next_cw(prev)) begin
                     dir = DIR_CW;
                  end else if (code == hsd_next_ccw(prev)) begin
                     dir = DIR_CCW;
                  end else begin
                     bad_step = 1'b1;
                  end
               end
               if (bad_step) begin
                  result.status = ST_BAD_STEP;
               end else begin
                  sector_in = hsd_code_sector(code);
                  if (dir == DIR_CW && steps_ff[item.motor] != STEPS_MAX) begin
                     steps_in = steps_ff[item.motor] + 32'sd1;
                  end else if (dir == DIR_CCW && steps_ff[item.motor] != STEPS_MIN) begin
                     steps_in = steps_ff[item.motor] - 32'sd1;
                  end
                  result.status    = ST_VALID;
                  result.sector    = sector_in;
                  result.steps     = steps_in;
                  result.direction = dir;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MOTORS; i++) begin
            first_pending_ff[i] <= 1'b1;
            curr_code_ff[i]     <= '0;
            sector_ff[i]        <= '0;
            steps_ff[i]         <= '0;
         end
      end else if (upd_en && wr) begin
         first_pending_ff[item.motor] <= first_pending_in;
         curr_code_ff[item.motor]     <= curr_code_in;
         sector_ff[item.motor]        <= sector_in;
         steps_ff[item.motor]         <= steps_in;
      end
   end

   // once seeded, a motor never holds an all-low or all-high code
   assert property (@(posedge clock) disable iff (reset)
      upd_en && wr && !first_pending_in |=>
         curr_code_ff[$past(item.motor)] != HALL_ALL_LOW &&
         curr_code_ff[$past(item.motor)] != HALL_ALL_HIGH)
      else $error("seeded motor holds an invalid hall code");

   assert property (@(posedge clock) disable iff (reset)
      result.direction != DIR_NONE |-> result.status == ST_VALID)
      else $error("step direction reported without a valid update");

   assert property (@(posedge clock) disable iff (reset)
      upd_en && result.status == ST_BAD_CODE |=>
         steps_ff[$past(item.motor)] == $past(steps_ff[item.motor]))
      else $error("invalid hall code changed the step count");

endmodule

// ===== hdl/bldc_hall_sector_decoder.sv =====
// Top level of the Hall sector decoder: request/response channels, APB registers,
// pipeline control and the mechanical angle multiplier.
// Depends on hsd_pkg, hsd_req_if, hsd_rsp_if and hsd_tracker.
//
// Usage:
//   req_chan takes one item per handshake: a Hall capture or a clear for one motor.
//   rsp_chan returns exactly one result item per request, in request order.
//   Items pass an input register, the per-motor state update (state is written as
//   the item leaves the input register) into a stage register, and a result
//   register where the 32x22 mechanical angle product is captured.
//   Throughput: one item per cycle while rsp_chan is not stalled; back-to-back
//   items on the same motor see the state left by the one before.
//   When rsp_chan stalls the three registers fill; req_chan.ready drops only when
//   all of them hold an item and the result is not being taken.
//   Reset (synchronous, active high) empties the pipeline, sets every motor to its
//   unseeded state with zero steps, wire order to identity, step angle to 60.0.
//   Registers: byte 0 wire order (3 bits), byte 4 step angle Q16 (22 bits).
//   Write registers only while no item is in flight.
module bldc_hall_sector_decoder import hsd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hsd_req_if.sink     req_chan,
   hsd_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [2:0]         wire_order_ff;
   logic [21:0]        step_angle_ff;

   logic               v0_ff, v1_ff, v2_ff;
   logic               adv0, adv1, adv2;

   trk_item_type       s0_item_ff;
   trk_result_type     s1_res_ff;
   trk_result_type     trk_res;

   logic signed [54:0] mech_in;

   logic [1:0]         status_ff;
   logic [2:0]         hall_code_ff;
   logic [2:0]         sector_ff;
   logic [8:0]         elec_ff;
   logic signed [1:0]  dir_ff;
   logic signed [31:0] steps_ff;
   logic signed [53:0] mech_ff;

   // ---------------- configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wire_order_ff <= WO_H3H2H1;
         step_angle_ff <= STEP_ANGLE_RESET;
      end else if (psel && penable && pwrite && pready) begin
         case (paddr[2])
            REG_WIRE_ORDER: wire_order_ff <= pwdata[2:0];
            REG_STEP_ANGLE: step_angle_ff <= pwdata[21:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_WIRE_ORDER: prdata = {29'd0, wire_order_ff};
         REG_STEP_ANGLE: prdata = {10'd0, step_angle_ff};
         default:        prdata = '0;
      endcase
   end

   // ---------------- pipeline control: each stage loads when it is empty or moves on
   assign adv2 = !v2_ff || rsp_chan.ready;
   assign adv1 = !v1_ff || adv2;
   assign adv0 = !v0_ff || adv1;
   assign req_chan.ready = adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= req_chan.valid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   // ---------------- input register
   always_ff @(posedge clock) begin
      if (adv0 && req_chan.valid) begin
         s0_item_ff.req_type  <= req_chan.req_type;
         s0_item_ff.motor     <= req_chan.motor;
         s0_item_ff.hall_bits <= req_chan.hall_bits;
      end
   end

   hsd_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .wire_order (wire_order_ff),
      .item       (s0_item_ff),
      .upd_en     (adv1 && v0_ff),
      .result     (trk_res)
   );

   always_ff @(posedge clock) begin
      if (adv1 && v0_ff) begin
         s1_res_ff <= trk_res;
      end
   end

   // ---------------- result register with the mechanical angle product
   assign mech_in = s1_res_ff.steps * $signed({1'b0, step_angle_ff});

   always_ff @(posedge clock) begin
      if (adv2 && v1_ff) begin
         status_ff    <= s1_res_ff.status;
         hall_code_ff <= s1_res_ff.hall_code;
         sector_ff    <= s1_res_ff.sector;
         elec_ff      <= hsd_sector_deg(s1_res_ff.sector);
         dir_ff       <= s1_res_ff.direction;
         steps_ff     <= s1_res_ff.steps;
         mech_ff      <= mech_in[53:0];
      end
   end

   assign rsp_chan.valid          = v2_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.hall_code      = hall_code_ff;
   assign rsp_chan.sector_index   = sector_ff;
   assign rsp_chan.electrical_deg = elec_ff;
   assign rsp_chan.direction      = dir_ff;
   assign rsp_chan.step_count     = steps_ff;
   assign rsp_chan.mech_angle_q16 = mech_ff;

   // ---------------- checks
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> v0_ff && v1_ff && v2_ff)
      else $error("request stalled with a free pipeline slot");

   assert property (@(posedge clock) disable iff (reset)
      v2_ff && status_ff == ST_CLEARED |->
         hall_code_ff == '0 && steps_ff == '0 && mech_ff == '0)
      else $error("clear result carries nonzero state");

   assert property (@(posedge clock) disable iff (reset)
      v2_ff && status_ff == ST_VALID |-> sector_ff <= 3'd5)
      else $error("valid update reports a sector out of range");

   assert property (@(posedge clock) disable iff (reset)
      v2_ff && steps_ff == '0 |-> mech_ff == '0)
      else $error("mechanical angle nonzero at zero steps");

endmodule

// ===== dv/bldc_hall_sector_decoder_test.sv =====
// Self-checking testbench for the Hall sector decoder: drives captures and clears,
// predicts each result item per motor, and checks it field by field.
// Depends on hsd_pkg, hsd_req_if, hsd_rsp_if and bldc_hall_sector_decoder.
module bldc_hall_sector_decoder_test;
   import hsd_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [2:0]         hall_code;
      logic [2:0]         sector;
      logic [8:0]         deg;
      logic signed [1:0]  dir;
      logic signed [31:0] steps;
      logic signed [53:0] mech;
   } hall_result_type;

   // successor and sector tables, entry c at bits [3*c +: 3]
   localparam logic [23:0] CW_NEXT  = {3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd3, 3'd5, 3'd0};
   localparam logic [23:0] CCW_NEXT = {3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd0};
   localparam logic [23:0] SECTOR_OF = {3'd0, 3'd1, 3'd5, 3'd0, 3'd3, 3'd2, 3'd4, 3'd0};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   hsd_req_if req_if ();
   hsd_rsp_if rsp_if ();

   bldc_hall_sector_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predicted motor state and register copies
   logic [2:0]         wiring;
   logic [21:0]        step_angle;
   logic               unseeded   [NUM_MOTORS];
   logic [2:0]         cur_code   [NUM_MOTORS];
   logic [2:0]         cur_sector [NUM_MOTORS];
   logic signed [31:0] hall_steps [NUM_MOTORS];

   trk_item_type    pending_items[$];
   hall_result_type decoded_q[$];
   hall_result_type want;
   int           n_sent = 0;
   int           n_done = 0;
   int           errors = 0;
   logic         calm = 1'b0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           stall_left = 0;
   int           cw_bias = 50;
   logic [2:0]   gen_code [NUM_MOTORS];

   initial forever #4 clock = ~clock;

   function automatic logic [2:0] rewire(input logic [2:0] order, input logic [2:0] x);
      logic [2:0] r;
      case (order)
         WO_H3H1H2: r = {x[2], x[0], x[1]};
         WO_H2H3H1: r = {x[1], x[2], x[0]};
         WO_H2H1H3: r = {x[1], x[0], x[2]};
         WO_H1H2H3: r = {x[0], x[1], x[2]};
         WO_H1H3H2: r = {x[0], x[2], x[1]};
         default:   r = x;
      endcase
      return r;
   endfunction

   // raw lines that the current wiring turns into the given code
   function automatic logic [2:0] raw_of(input logic [2:0] code);
      logic [2:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         if (rewire(wiring, 3'(k)) == code) r = 3'(k);
      end
      return r;
   endfunction

   function automatic hall_result_type decode_hall(input logic clr, input logic [1:0] m,
                                                   input logic [2:0] raw);
      hall_result_type r;
      logic [2:0] code;
      logic [2:0] last;
      r = '0;
      r.dir = DIR_NONE;
      if (clr) begin
         unseeded[m] = 1'b1;
         cur_code[m] = '0;
         cur_sector[m] = '0;
         hall_steps[m] = '0;
         r.status = ST_CLEARED;
         return r;
      end
      code = rewire(wiring, raw);
      if (code == HALL_ALL_LOW || code == HALL_ALL_HIGH) begin
         r.status = ST_BAD_CODE;
      end else begin
         // the first capture after a clear seeds both codes
         last = unseeded[m] ? code : cur_code[m];
         unseeded[m] = 1'b0;
         cur_code[m] = code;
         if (code != last && code != CW_NEXT[3*last +: 3] && code != CCW_NEXT[3*last +: 3]) begin
            r.status = ST_BAD_STEP;
         end else begin
            r.status = ST_VALID;
            if (code == last) r.dir = DIR_NONE;
            else if (code == CW_NEXT[3*last +: 3]) r.dir = DIR_CW;
            else r.dir = DIR_CCW;
            cur_sector[m] = SECTOR_OF[3*code +: 3];
            if (r.dir == DIR_CW && hall_steps[m] != STEPS_MAX) hall_steps[m] += 1;
            else if (r.dir == DIR_CCW && hall_steps[m] != STEPS_MIN) hall_steps[m] -= 1;
         end
      end
      r.hall_code = cur_code[m];
      r.sector = cur_sector[m];
      r.deg = 9'(cur_sector[m] * 60);
      r.steps = hall_steps[m];
      r.mech = 54'(longint'(hall_steps[m]) * longint'({10'd0, step_angle}));
      return r;
   endfunction

   task automatic check_field(input string name, input logic signed [63:0] exp_v,
                              input logic signed [63:0] got_v);
      if (got_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, got_v);
         errors++;
      end
   endtask

   task automatic queue_item(input logic clr, input logic [1:0] m, input logic [2:0] bits);
      trk_item_type it;
      it.req_type = clr;
      it.motor = m;
      it.hall_bits = bits;
      pending_items.push_back(it);
      n_sent++;
   endtask

   // mostly rotation runs on one motor, with clears, bad codes and random jumps mixed in
   task automatic queue_random(input int n);
      int pick;
      logic [1:0] m;
      logic [2:0] c;
      m = 2'($urandom_range(0, NUM_MOTORS - 1));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 3) == 0) m = 2'($urandom_range(0, NUM_MOTORS - 1));
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            queue_item(REQ_CLEAR, m, 3'($urandom_range(0, 7)));
            gen_code[m] = '0;
         end else if (pick < 8) begin
            queue_item(REQ_CAPTURE, m, $urandom_range(0, 1) ? HALL_ALL_HIGH : HALL_ALL_LOW);
         end else if (pick < 14) begin
            c = 3'($urandom_range(0, 7));
            if (rewire(wiring, c) != HALL_ALL_LOW && rewire(wiring, c) != HALL_ALL_HIGH)
               gen_code[m] = rewire(wiring, c);
            queue_item(REQ_CAPTURE, m, c);
         end else begin
            if (gen_code[m] == HALL_ALL_LOW) c = 3'($urandom_range(1, 6));
            else if (pick < 20) c = gen_code[m];
            else if ($urandom_range(0, 99) < cw_bias) c = CW_NEXT[3*gen_code[m] +: 3];
            else c = CCW_NEXT[3*gen_code[m] +: 3];
            gen_code[m] = c;
            queue_item(REQ_CAPTURE, m, raw_of(c));
         end
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // hold until every queued item has come back
   task automatic drain();
      do @(negedge clock); while (n_done != n_sent);
   endtask

   // sender: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            decoded_q.push_back(decode_hall(req_if.req_type, req_if.motor, req_if.hall_bits));
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0 && !calm) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               trk_item_type it;
               it = pending_items.pop_front();
               req_if.valid <= 1'b1;
               req_if.req_type <= it.req_type;
               req_if.motor <= it.motor;
               req_if.hall_bits <= it.hall_bits;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls, compare each item with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_q.size() == 0) begin
               $error("result item with no prediction waiting");
               errors++;
            end else begin
               want = decoded_q.pop_front();
               check_field("status", want.status, rsp_if.status);
               check_field("hall_code", want.hall_code, rsp_if.hall_code);
               check_field("sector_index", want.sector, rsp_if.sector_index);
               check_field("electrical_deg", want.deg, rsp_if.electrical_deg);
               check_field("direction", want.dir, rsp_if.direction);
               check_field("step_count", want.steps, rsp_if.step_count);
               check_field("mech_angle_q16", want.mech, rsp_if.mech_angle_q16);
               n_done++;
            end
         end
         if (calm) begin
            rsp_if.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 7);
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.req_type = REQ_CAPTURE;
      req_if.motor = '0;
      req_if.hall_bits = '0;
      rsp_if.ready = 1'b0;
      wiring = WO_H3H2H1;
      step_angle = STEP_ANGLE_RESET;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         unseeded[m] = 1'b1;
         cur_code[m] = '0;
         cur_sector[m] = '0;
         hall_steps[m] = '0;
         gen_code[m] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: bad codes, seeding, a full clockwise turn, a step back, a jump, clears
      queue_item(REQ_CAPTURE, 2'd0, HALL_ALL_LOW);
      queue_item(REQ_CAPTURE, 2'd0, HALL_ALL_HIGH);
      queue_item(REQ_CAPTURE, 2'd0, 3'd4);
      queue_item(REQ_CAPTURE, 2'd0, 3'd4);
      queue_item(REQ_CAPTURE, 2'd0, 3'd6);
      queue_item(REQ_CAPTURE, 2'd0, 3'd2);
      queue_item(REQ_CAPTURE, 2'd0, 3'd3);
      queue_item(REQ_CAPTURE, 2'd0, 3'd1);
      queue_item(REQ_CAPTURE, 2'd0, 3'd5);
      queue_item(REQ_CAPTURE, 2'd0, 3'd4);
      queue_item(REQ_CAPTURE, 2'd0, 3'd5);
      queue_item(REQ_CAPTURE, 2'd0, 3'd2);
      queue_item(REQ_CAPTURE, 2'd0, 3'd3);
      queue_item(REQ_CLEAR, 2'd0, 3'd7);
      queue_item(REQ_CAPTURE, 2'd0, 3'd3);
      queue_item(REQ_CAPTURE, 2'd3, 3'd1);
      queue_item(REQ_CAPTURE, 2'd3, 3'd3);
      queue_item(REQ_CAPTURE, 2'd3, HALL_ALL_HIGH);
      queue_item(REQ_CAPTURE, 2'd1, 3'd6);
      queue_item(REQ_CAPTURE, 2'd2, 3'd2);
      queue_item(REQ_CLEAR, 2'd2, 3'd0);
      queue_item(REQ_CLEAR, 2'd2, 3'd5);
      drain();

      // every wiring order; step angles of the smallest nonzero value, zero, 60.0 and random ones up to 60.0
      for (int p = 0; p < 8; p++) begin
         logic [2:0]  order;
         logic [21:0] angle;
         order = 3'(p + 1);
         case (p)
            0:       angle = 22'd1;
            1:       angle = '0;
            3:       angle = STEP_ANGLE_RESET;
            default: angle = 22'($urandom_range(1, 3932160));
         endcase
         csr_write({REG_WIRE_ORDER, 2'b00}, {29'd0, order});
         csr_write({REG_STEP_ANGLE, 2'b00}, {10'd0, angle});
         wiring = order;
         step_angle = angle;
         calm = (p == 2 || p == 5);
         cw_bias = $urandom_range(10, 90);
         @(negedge clock);
         queue_random(180);
         drain();
      end

      repeat (8) @(posedge clock);
      if (decoded_q.size() != 0) begin
         $error("%0d predicted result items never arrived", decoded_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
